/* src/cooperative_task_timer_table_macros.svh */
// Assertion macros used by the task timer table sequencer
`ifndef COOPERATIVE_TASK_TIMER_TABLE_MACROS_SVH
`define COOPERATIVE_TASK_TIMER_TABLE_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define CTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define CTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ctt_pkg.sv */
// Shared types and codes for the task timer table
package ctt_pkg;

  localparam int unsigned SLOT_IDX_W = 6;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_DISP = 2'd3
  } ctt_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } ctt_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_RESP
  } ctt_state_e;

  typedef struct packed {
    ctt_status_e           status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [7:0]            run_task;
    logic                  ran;
    logic                  last;
  } ctt_result_t;

endpackage

/* src/cooperative_task_timer_table.sv */
// Cooperative task timer table: top level
//
// Input channel: in_valid_i / in_stall_o with command_i, task_id_i,
// first_delay_i, repeat_period_i and slot_i. An item is taken when valid is
// high and stall is low; stall is high while a command is in progress.
// Output channel: out_valid_o / out_stall_i with status_o, slot_index_o,
// run_task_o, ran_o and last_o. Each command yields one or more items; the
// final one carries last_o.
// Commands run one at a time. Add checks one slot per cycle until it finds
// a free slot or reaches the last one. Tick and dispatch walk the slot
// memory one slot per cycle while a dispatch walk is not paused; the walk
// keeps the input stalled until the command's final item is sent.
// Reset clears all occupancy bits, so every slot starts free; the slot
// memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item; a dispatch
// walk pauses at the next due slot until the register frees.
module cooperative_task_timer_table
  import ctt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [7:0]            task_id_i,
  input  logic [15:0]           first_delay_i,
  input  logic [15:0]           repeat_period_i,
  input  logic [7:0]            slot_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  output logic [7:0]            run_task_o,
  output logic                  ran_o,
  output logic                  last_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned DW = 16 + 2 * TIME_WIDTH;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic          push;
  ctt_result_t   push_res;
  logic          out_free;
  ctt_result_t   out_res;

  ctt_ctrl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_WIDTH (TIME_WIDTH),
    .IW         (IW),
    .DW         (DW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .task_id_i       (task_id_i),
    .first_delay_i   (first_delay_i),
    .repeat_period_i (repeat_period_i),
    .slot_i          (slot_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .push_o          (push),
    .push_res_o      (push_res),
    .out_free_i      (out_free)
  );

  ctt_slot_ram #(
    .DW    (DW),
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (push_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign status_o     = out_res.status;
  assign slot_index_o = out_res.slot_index;
  assign run_task_o   = out_res.run_task;
  assign ran_o        = out_res.ran;
  assign last_o       = out_res.last;

endmodule

/* src/ctt_slot_ram.sv */
// Slot record memory, one write and one registered read port
module ctt_slot_ram #(
  parameter int unsigned DW    = 48,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/ctt_out_reg.sv */
// Output register for result items
module ctt_out_reg
  import ctt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ctt_result_t push_res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ctt_result_t out_res_o
);

  logic        valid_q, valid_d;
  ctt_result_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= push_res_i;
    end
  end

endmodule

/* src/ctt_ctrl.sv */
// Command sequencer: slot walk, read-modify-write of the slot memory
`include "cooperative_task_timer_table_macros.svh"

module ctt_ctrl
  import ctt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TIME_WIDTH = 16,
  parameter int unsigned IW         = 4,
  parameter int unsigned DW         = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [7:0]            task_id_i,
  input  logic [15:0]           first_delay_i,
  input  logic [15:0]           repeat_period_i,
  input  logic [7:0]            slot_i,
  output logic                  ram_we_o,
  output logic [IW-1:0]         ram_waddr_o,
  output logic [DW-1:0]         ram_wdata_o,
  output logic                  ram_re_o,
  output logic [IW-1:0]         ram_raddr_o,
  input  logic [DW-1:0]         ram_rdata_i,
  output logic                  push_o,
  output ctt_result_t           push_res_o,
  input  logic                  out_free_i
);

  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] END_IDX  = CW'(NUM_SLOTS);

  typedef struct packed {
    logic [7:0]            task_id;
    logic [TIME_WIDTH-1:0] delay;
    logic [TIME_WIDTH-1:0] period;
    logic [7:0]            pending;
  } slot_rec_t;

  localparam ctt_result_t RES_EMPTY = '{status: STAT_OK, slot_index: '0,
                                        run_task: '0, ran: 1'b0, last: 1'b1};

  ctt_state_e            state_q, state_d;
  ctt_cmd_e              cmd_q, cmd_d;
  logic [7:0]            id_q, id_d;
  logic [TIME_WIDTH-1:0] dly_q, dly_d;
  logic [TIME_WIDTH-1:0] per_q, per_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  proc_v_q, proc_v_d;
  logic [IW-1:0]         proc_idx_q, proc_idx_d;
  logic                  held_v_q, held_v_d;
  ctt_result_t           held_q, held_d;
  ctt_result_t           res_q, res_d;
  logic [NUM_SLOTS-1:0]  occ_q, occ_d;

  logic      in_acc;
  logic      del_ok;
  logic      scan_done;
  logic      proc_occ;
  logic      disp_hit;
  logic      scan_stall;
  slot_rec_t rec_rd;
  slot_rec_t rec_wr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rec_rd     = slot_rec_t'(ram_rdata_i);
  assign del_ok     = (9'(slot_i) < 9'(NUM_SLOTS)) && occ_q[slot_i[IW-1:0]];
  assign scan_done  = (idx_q == END_IDX) && !proc_v_q;
  assign proc_occ   = proc_v_q && occ_q[proc_idx_q];
  assign disp_hit   = proc_occ && (rec_rd.pending != 8'd0);
  assign scan_stall = (cmd_q == CMD_DISP) && disp_hit && held_v_q && !out_free_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (ctt_cmd_e'(command_i))
            CMD_ADD:  state_d = (task_id_i == 8'd0) ? ST_RESP : ST_ADD;
            CMD_DEL:  state_d = ST_RESP;
            CMD_TICK: state_d = ST_SCAN;
            CMD_DISP: state_d = ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (!occ_q[idx_q[IW-1:0]] || (idx_q == LAST_IDX)) begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    id_d        = id_q;
    dly_d       = dly_q;
    per_d       = per_q;
    idx_d       = idx_q;
    proc_v_d    = proc_v_q;
    proc_idx_d  = proc_idx_q;
    held_v_d    = held_v_q;
    held_d      = held_q;
    res_d       = res_q;
    occ_d       = occ_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    push_o      = 1'b0;
    push_res_o  = res_q;
    rec_wr      = rec_rd;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d    = ctt_cmd_e'(command_i);
          id_d     = task_id_i;
          dly_d    = TIME_WIDTH'(first_delay_i);
          per_d    = TIME_WIDTH'(repeat_period_i);
          idx_d    = '0;
          proc_v_d = 1'b0;
          held_v_d = 1'b0;
          res_d    = RES_EMPTY;
          if (ctt_cmd_e'(command_i) == CMD_ADD) begin
            res_d.status = STAT_BAD;
          end else if (ctt_cmd_e'(command_i) == CMD_DEL) begin
            if (del_ok) begin
              occ_d[slot_i[IW-1:0]] = 1'b0;
              res_d.slot_index      = SLOT_IDX_W'(slot_i[IW-1:0]);
            end else begin
              res_d.status = STAT_BAD;
            end
          end
        end
      end
      ST_ADD: begin
        if (!occ_q[idx_q[IW-1:0]]) begin
          rec_wr            = '{task_id: id_q, delay: dly_q, period: per_q, pending: 8'd0};
          ram_we_o          = 1'b1;
          ram_waddr_o       = idx_q[IW-1:0];
          ram_wdata_o       = DW'(rec_wr);
          occ_d[idx_q[IW-1:0]] = 1'b1;
          res_d             = RES_EMPTY;
          res_d.slot_index  = SLOT_IDX_W'(idx_q[IW-1:0]);
        end else if (idx_q == LAST_IDX) begin
          res_d        = RES_EMPTY;
          res_d.status = STAT_FULL;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_d = RES_EMPTY;
          if ((cmd_q == CMD_DISP) && held_v_q) begin
            res_d      = held_q;
            res_d.last = 1'b1;
          end
        end else if (!scan_stall) begin
          if (idx_q != END_IDX) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_q[IW-1:0];
            proc_v_d    = 1'b1;
            proc_idx_d  = idx_q[IW-1:0];
            idx_d       = idx_q + CW'(1);
          end else begin
            proc_v_d = 1'b0;
          end
          if (cmd_q == CMD_TICK) begin
            if (proc_occ) begin
              if (rec_rd.delay == '0) begin
                if (rec_rd.pending != 8'hFF) begin
                  rec_wr.pending = rec_rd.pending + 8'd1;
                end
                if (rec_rd.period != '0) begin
                  rec_wr.delay = rec_rd.period;
                end
              end else begin
                rec_wr.delay = rec_rd.delay - TIME_WIDTH'(1);
              end
              ram_we_o    = 1'b1;
              ram_waddr_o = proc_idx_q;
              ram_wdata_o = DW'(rec_wr);
            end
          end else if (disp_hit) begin
            rec_wr.pending = rec_rd.pending - 8'd1;
            ram_we_o       = 1'b1;
            ram_waddr_o    = proc_idx_q;
            ram_wdata_o    = DW'(rec_wr);
            if (rec_rd.period == '0) begin
              occ_d[proc_idx_q] = 1'b0;
            end
            if (held_v_q) begin
              push_o     = 1'b1;
              push_res_o = held_q;
            end
            held_v_d = 1'b1;
            held_d   = '{status: STAT_OK, slot_index: SLOT_IDX_W'(proc_idx_q),
                         run_task: rec_rd.task_id, ran: 1'b1, last: 1'b0};
          end
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          push_res_o = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      proc_v_q <= 1'b0;
      held_v_q <= 1'b0;
      occ_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      proc_v_q <= proc_v_d;
      held_v_q <= held_v_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    dly_q      <= dly_d;
    per_q      <= per_d;
    proc_idx_q <= proc_idx_d;
    held_q     <= held_d;
    res_q      <= res_d;
  end

  `CTT_ASSERT_IMP(a_push_free, push_o, out_free_i, "result pushed into a full output register")
  `CTT_ASSERT_IMP(a_ram_apart, ram_we_o && ram_re_o, ram_waddr_o != ram_raddr_o,
                  "slot memory read and write hit the same entry")
  `CTT_ASSERT_IMP(a_stall_held, (state_q == ST_SCAN) && scan_stall, held_v_q,
                  "scan stalled without a held item")
  `CTT_ASSERT_NXT(a_resp_done, (state_q == ST_RESP) && out_free_i, state_q == ST_IDLE,
                  "final item sent but sequencer not idle")

endmodule
